// File: src/npl_pkg.sv
// ----------------------------------------------------------------------------
// npl_pkg
// Shared sizes, types and state codes of the next-permutation core.
// ----------------------------------------------------------------------------
package npl_pkg;

  localparam int unsigned MaxLen    = 16;
  localparam int unsigned ElemWidth = 16;
  localparam int unsigned AddrW     = $clog2(MaxLen);
  localparam int unsigned CntW      = $clog2(MaxLen + 1);

  typedef logic [ElemWidth-1:0] elem_t;
  typedef logic [AddrW-1:0]     addr_t;
  typedef logic [CntW-1:0]      cnt_t;

  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_PSCAN  = 6'b000010,
    ST_SSCAN  = 6'b000100,
    ST_SWAP_P = 6'b001000,
    ST_SWAP_S = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  // Sequencer to output stage: load the RAM read data with these flags.
  typedef struct packed {
    logic load;
    logic last;
    logic wrapped;
    logic ovf;
  } emit_t;

endpackage

// File: src/npl_in_if.sv
// ----------------------------------------------------------------------------
// npl_in_if
// Input channel: one sequence element per item, last one marked.
// ----------------------------------------------------------------------------
interface npl_in_if;
  import npl_pkg::*;

  logic  valid;
  logic  ready;
  elem_t elem_value;
  logic  is_final;

  modport source (output valid, output elem_value, output is_final, input ready);
  modport sink   (input valid, input elem_value, input is_final, output ready);
endinterface

// File: src/npl_out_if.sv
// ----------------------------------------------------------------------------
// npl_out_if
// Output channel: one element of the next permutation per item.
// ----------------------------------------------------------------------------
interface npl_out_if;
  import npl_pkg::*;

  logic  valid;
  logic  ready;
  elem_t out_value;
  logic  out_final;
  logic  wrapped;
  logic  overflowed;

  modport source (output valid, output out_value, output out_final, output wrapped,
                  output overflowed, input ready);
  modport sink   (input valid, input out_value, input out_final, input wrapped,
                  input overflowed, output ready);
endinterface

// File: src/npl_ram.sv
// ----------------------------------------------------------------------------
// npl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npl_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/npl_ctrl.sv
// ----------------------------------------------------------------------------
// npl_ctrl
// Sequencer: loads elements, scans for pivot and successor, swaps in
// place and streams the result with the suffix read in reverse order.
// ----------------------------------------------------------------------------
module npl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  npl_pkg::elem_t in_value_i,
  input  logic           in_final_i,
  output logic           in_ready_o,
  input  logic           out_free_i,
  input  npl_pkg::elem_t rdata_i,
  output logic           we_o,
  output npl_pkg::addr_t waddr_o,
  output npl_pkg::elem_t wdata_o,
  output npl_pkg::addr_t raddr_o,
  output npl_pkg::emit_t emit_o
);
  import npl_pkg::*;

  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;
  logic   ovf_q, ovf_d;
  cnt_t   n_q, n_d;
  addr_t  ra_q, ra_d;
  logic   iss_q, iss_d;
  logic   rv_q, rv_d;
  addr_t  la_q, la_d;
  elem_t  prev_q, prev_d;
  addr_t  piv_q, piv_d;
  elem_t  pv_q, pv_d;
  addr_t  suc_q, suc_d;
  elem_t  sv_q, sv_d;
  logic   wrap_q, wrap_d;
  cnt_t   k_q, k_d;
  cnt_t   rs_q, rs_d;
  logic   last_q, last_d;

  logic           full;
  cnt_t           cnt_inc;
  cnt_t           n_new;
  cnt_t           n_new_m1;
  cnt_t           n_m1_c;
  addr_t          n_m1;
  logic [CntW:0]  rev_idx;
  addr_t          e_addr;

  assign full     = (cnt_q == cnt_t'(MaxLen));
  assign cnt_inc  = cnt_q + cnt_t'(1);
  assign n_new    = full ? cnt_q : cnt_inc;
  assign n_new_m1 = n_new - cnt_t'(1);
  assign n_m1_c   = n_q - cnt_t'(1);
  assign n_m1     = n_m1_c[AddrW-1:0];

  // Suffix after the pivot comes out reversed: index n-1+rs-k.
  assign rev_idx = {1'b0, n_q} - {{CntW{1'b0}}, 1'b1} + {1'b0, rs_q} - {1'b0, k_q};
  assign e_addr  = (k_q < rs_q) ? k_q[AddrW-1:0] : rev_idx[AddrW-1:0];

  assign in_ready_o = (state_q == ST_LOAD);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    n_d     = n_q;
    ra_d    = ra_q;
    iss_d   = iss_q;
    rv_d    = rv_q;
    la_d    = la_q;
    prev_d  = prev_q;
    piv_d   = piv_q;
    pv_d    = pv_q;
    suc_d   = suc_q;
    sv_d    = sv_q;
    wrap_d  = wrap_q;
    k_d     = k_q;
    rs_d    = rs_q;
    last_d  = last_q;
    we_o    = 1'b0;
    waddr_o = cnt_q[AddrW-1:0];
    wdata_o = in_value_i;
    raddr_o = ra_q;
    emit_o  = '0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          if (!full) begin
            we_o  = 1'b1;
            cnt_d = cnt_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_final_i) begin
            n_d     = n_new;
            ra_d    = n_new_m1[AddrW-1:0];
            iss_d   = 1'b1;
            rv_d    = 1'b0;
            wrap_d  = 1'b0;
            state_d = ST_PSCAN;
          end
        end
      end

      // Reads go out one per cycle from the right; each compare works on the registered read data.
      ST_PSCAN: begin
        if (iss_q) begin
          if (ra_q == '0) iss_d = 1'b0;
          else            ra_d  = ra_q - addr_t'(1);
        end
        rv_d = iss_q;
        la_d = ra_q;
        if (rv_q) begin
          prev_d = rdata_i;
          if (la_q != n_m1 && rdata_i < prev_q) begin
            piv_d   = la_q;
            pv_d    = rdata_i;
            ra_d    = n_m1;
            iss_d   = 1'b1;
            rv_d    = 1'b0;
            state_d = ST_SSCAN;
          end else if (la_q == '0) begin
            // no ascent: emit whole sequence reversed
            wrap_d  = 1'b1;
            rs_d    = '0;
            k_d     = '0;
            rv_d    = 1'b0;
            state_d = ST_EMIT;
          end
        end
      end

      // The element right of the pivot is larger, so this always hits.
      ST_SSCAN: begin
        if (iss_q) begin
          if (ra_q == '0) iss_d = 1'b0;
          else            ra_d  = ra_q - addr_t'(1);
        end
        rv_d = iss_q;
        la_d = ra_q;
        if (rv_q && rdata_i > pv_q) begin
          suc_d   = la_q;
          sv_d    = rdata_i;
          rv_d    = 1'b0;
          state_d = ST_SWAP_P;
        end
      end

      ST_SWAP_P: begin
        we_o    = 1'b1;
        waddr_o = piv_q;
        wdata_o = sv_q;
        state_d = ST_SWAP_S;
      end

      ST_SWAP_S: begin
        we_o    = 1'b1;
        waddr_o = suc_q;
        wdata_o = pv_q;
        rs_d    = cnt_t'(piv_q) + cnt_t'(1);
        k_d     = '0;
        state_d = ST_EMIT;
      end

      // One read in flight at most; issued only when the output register
      // is sure to be empty when the data lands.
      ST_EMIT: begin
        raddr_o = e_addr;
        if (!rv_q && out_free_i) begin
          rv_d   = 1'b1;
          last_d = (k_q == n_m1_c);
          k_d    = k_q + cnt_t'(1);
        end
        if (rv_q) begin
          emit_o.load    = 1'b1;
          emit_o.last    = last_q;
          emit_o.wrapped = wrap_q;
          emit_o.ovf     = ovf_q;
          rv_d           = 1'b0;
          if (last_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end
        end
      end

      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      iss_q   <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      iss_q   <= iss_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    ra_q   <= ra_d;
    la_q   <= la_d;
    prev_q <= prev_d;
    piv_q  <= piv_d;
    pv_q   <= pv_d;
    suc_q  <= suc_d;
    sv_q   <= sv_d;
    wrap_q <= wrap_d;
    k_q    <= k_d;
    rs_q   <= rs_d;
    last_q <= last_d;
  end

endmodule

// File: src/npl_out.sv
// ----------------------------------------------------------------------------
// npl_out
// Output register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module npl_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  npl_pkg::emit_t    emit_i,
  input  npl_pkg::elem_t    rdata_i,
  output logic              free_o,
  npl_out_if.source         out_o
);
  import npl_pkg::*;

  logic  valid_q, valid_d;
  elem_t value_q;
  logic  final_q;
  logic  wrap_q;
  logic  ovf_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (emit_i.load)      valid_d = 1'b1;
    else if (out_o.ready) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.load) begin
      value_q <= rdata_i;
      final_q <= emit_i.last;
      wrap_q  <= emit_i.wrapped;
      ovf_q   <= emit_i.ovf;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_value  = value_q;
  assign out_o.out_final  = final_q;
  assign out_o.wrapped    = wrap_q;
  assign out_o.overflowed = ovf_q;

endmodule

// File: src/next_lexicographic_permutation_core.sv
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_core
// Loads a sequence and streams out its next lexicographic permutation.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  takes one element per item; is_final marks the last one. Up to
//         MaxLen elements are stored, later ones are dropped and flagged.
//   out_o gives one item per stored element, out_final on the last one;
//         wrapped and overflowed are the same on every item of a sequence.
// Flow:
//   load: in_i ready whenever the block is loading.
//   pivot scan: reads from the right down to the pivot; successor scan:
//   reads from the right down to the successor; swap: two writes; emission:
//   one read in flight at most. Scans and emission share the single read
//   port of the element RAM, whose read data is registered.
//   in_i is not ready from the final element until the last result is in
//   the output register.
// Reset: clears the element count, overflow flag and control state; the
//   element RAM is not cleared, only entries of the current load are read.
// Stall: a result stays in the output register while out_o.ready is low and
//   no further RAM read is issued until it is taken.
// ----------------------------------------------------------------------------
module next_lexicographic_permutation_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  npl_in_if.sink     in_i,
  npl_out_if.source  out_o
);
  import npl_pkg::*;

  logic  we;
  addr_t waddr;
  elem_t wdata;
  addr_t raddr;
  elem_t rdata;
  logic  out_free;
  emit_t emit;
  logic  in_ready;

  npl_ram #(
    .Width (ElemWidth),
    .Depth (MaxLen)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  npl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_value_i (in_i.elem_value),
    .in_final_i (in_i.is_final),
    .in_ready_o (in_ready),
    .out_free_i (out_free),
    .rdata_i    (rdata),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .emit_o     (emit)
  );

  assign in_i.ready = in_ready;

  npl_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .emit_i  (emit),
    .rdata_i (rdata),
    .free_o  (out_free),
    .out_o   (out_o)
  );

endmodule

// File: tb/sv/npl_perm_checker.sv
// ----------------------------------------------------------------------------
// npl_perm_checker
// Watches both channels of the next-permutation core, rebuilds each loaded
// sequence, works out its next lexicographic permutation and compares every
// emitted item field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module npl_perm_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  npl_pkg::elem_t in_value_i,
  input  logic           in_final_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  npl_pkg::elem_t out_value_i,
  input  logic           out_final_i,
  input  logic           out_wrapped_i,
  input  logic           out_ovf_i,
  output int unsigned    mismatch_cnt_o,
  output int unsigned    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import npl_pkg::*;

  typedef struct packed {
    elem_t value;
    logic  last;
    logic  wrapped;
    logic  ovf;
  } perm_elem_t;

  elem_t      seq_store [MaxLen];
  cnt_t       stored_cnt = '0;
  logic       drop_seen  = 1'b0;
  perm_elem_t perm_q [$];
  perm_elem_t want;

  task automatic swap_elems(input int unsigned a, input int unsigned b);
    elem_t t;
    t            = seq_store[a];
    seq_store[a] = seq_store[b];
    seq_store[b] = t;
  endtask

  task automatic reverse_span(input int unsigned lo, input int unsigned hi_excl);
    while (lo + 1 < hi_excl) begin
      hi_excl--;
      swap_elems(lo, hi_excl);
      lo++;
    end
  endtask

  // Rightmost ascent is the pivot; no ascent means last permutation -> wrap.
  task automatic queue_next_perm();
    int unsigned n;
    int unsigned pivot;
    int unsigned i;
    logic        wrap;
    perm_elem_t  entry;
    n     = stored_cnt;
    wrap  = 1'b1;
    pivot = 0;
    for (i = n - 1; i > 0; i--) begin
      if (seq_store[i-1] < seq_store[i]) begin
        pivot = i - 1;
        wrap  = 1'b0;
        break;
      end
    end
    if (wrap) begin
      reverse_span(0, n);
    end else begin
      for (i = n - 1; i > pivot; i--) begin
        if (seq_store[i] > seq_store[pivot]) begin
          swap_elems(i, pivot);
          break;
        end
      end
      reverse_span(pivot + 1, n);
    end
    for (i = 0; i < n; i++) begin
      entry.value   = seq_store[i];
      entry.last    = (i + 1 == n);
      entry.wrapped = wrap;
      entry.ovf     = drop_seen;
      perm_q        = {perm_q, entry};
    end
    stored_cnt = '0;
    drop_seen  = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_cnt     = '0;
      drop_seen      = 1'b0;
      mismatch_cnt_o = 0;
      perm_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (perm_q.size() == 0) begin
          $error("out_value: expected nothing, got %h", out_value_i);
          mismatch_cnt_o++;
        end else begin
          want = perm_q.pop_front();
          if (out_value_i !== want.value) begin
            $error("out_value: expected %h, got %h", want.value, out_value_i);
            mismatch_cnt_o++;
          end
          if (out_final_i !== want.last) begin
            $error("out_final: expected %b, got %b", want.last, out_final_i);
            mismatch_cnt_o++;
          end
          if (out_wrapped_i !== want.wrapped) begin
            $error("wrapped: expected %b, got %b", want.wrapped, out_wrapped_i);
            mismatch_cnt_o++;
          end
          if (out_ovf_i !== want.ovf) begin
            $error("overflowed: expected %b, got %b", want.ovf, out_ovf_i);
            mismatch_cnt_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        // store full: the item is dropped, a final one still triggers the pass
        if (stored_cnt < MaxLen) begin
          seq_store[stored_cnt[AddrW-1:0]] = in_value_i;
          stored_cnt++;
        end else begin
          drop_seen = 1'b1;
        end
        if (in_final_i) queue_next_perm();
      end
    end
    pending_o = perm_q.size();
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives sequences into the next-permutation core: directed corner cases,
// then random sequences of varied length and shape, with random idling on
// both channels and one long output hold-off. Checking is in npl_perm_checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import npl_pkg::*;

  localparam int unsigned TotalItems     = 220;
  localparam int unsigned QuietFrom      = 190;
  localparam int unsigned LongHoldAt     = 70;
  localparam int unsigned LongHoldCycles = 250;
  localparam int unsigned DrainCycles    = 100;
  localparam int unsigned CycleLimit     = 200000;

  typedef enum int unsigned {
    SHAPE_WIDE,
    SHAPE_NARROW,
    SHAPE_DESC,
    SHAPE_ASC,
    SHAPE_NARROW_DESC
  } seq_shape_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned elems_sent    = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned stall_left    = 0;
  bit          quiet         = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned mismatch_cnt;
  int unsigned pending;

  npl_in_if  in_ch ();
  npl_out_if out_ch ();

  next_lexicographic_permutation_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  npl_perm_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_ch.valid),
    .in_ready_i     (in_ch.ready),
    .in_value_i     (in_ch.elem_value),
    .in_final_i     (in_ch.is_final),
    .out_valid_i    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .out_value_i    (out_ch.out_value),
    .out_final_i    (out_ch.out_final),
    .out_wrapped_i  (out_ch.wrapped),
    .out_ovf_i      (out_ch.overflowed),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side: random stall bursts, one long hold-off while input keeps coming.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LongHoldCycles;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Leaves valid high after acceptance; the next call lowers it only for a gap.
  task automatic send_elem(input elem_t value, input logic fin);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.elem_value <= value;
    in_ch.is_final   <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    elems_sent++;
    if (elems_sent == LongHoldAt) long_hold_req = 1'b1;
    quiet = (elems_sent >= QuietFrom);
  endtask

  task automatic send_seq(input elem_t seq[$]);
    for (int unsigned i = 0; i < seq.size(); i++) begin
      send_elem(seq[i], i + 1 == seq.size());
    end
  endtask

  initial begin
    elem_t       seq [$];
    int unsigned len;
    int unsigned len_pick;
    seq_shape_e  shape;

    in_ch.valid      <= 1'b0;
    in_ch.elem_value <= '0;
    in_ch.is_final   <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single element wraps onto itself
    seq = '{16'hffff};
    send_seq(seq);
    seq = '{16'h0000, 16'hffff};
    send_seq(seq);
    seq = '{16'hffff, 16'h0000};
    send_seq(seq);
    // all equal: no strict ascent
    seq = '{16'h5a5a, 16'h5a5a, 16'h5a5a};
    send_seq(seq);
    // one past a full store; the final item itself is dropped
    seq.delete();
    for (int unsigned k = 0; k <= MaxLen; k++) seq = {seq, elem_t'(k * 4099)};
    send_seq(seq);

    while (elems_sent < TotalItems) begin
      len_pick = $urandom_range(0, 99);
      if (len_pick < 80)      len = $urandom_range(1, 6);
      else if (len_pick < 92) len = $urandom_range(7, MaxLen);
      else                    len = $urandom_range(MaxLen + 1, MaxLen + 4);
      shape = seq_shape_e'($urandom_range(0, 4));
      seq.delete();
      repeat (len) begin
        if (shape == SHAPE_NARROW || shape == SHAPE_NARROW_DESC)
          seq = {seq, elem_t'($urandom_range(0, 3))};
        else
          seq = {seq, elem_t'($urandom)};
      end
      if (shape == SHAPE_DESC || shape == SHAPE_NARROW_DESC) seq.rsort();
      else if (shape == SHAPE_ASC) seq.sort();
      send_seq(seq);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
src/npl_pkg.sv
src/npl_in_if.sv
src/npl_out_if.sv
src/npl_ram.sv
src/npl_ctrl.sv
src/npl_out.sv
src/next_lexicographic_permutation_core.sv
tb/sv/npl_perm_checker.sv
tb/sv/testbench.sv
